### rtl/vcr_pkg.sv
`default_nettype none
package vcr_pkg;

  localparam int unsigned OUT_BITS  = 10;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned TICK_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 20;

  localparam logic [7:0]        ASCII_ONE   = 8'h31;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 20'd30000;
  localparam logic [7:0]        POLY_RST    = 8'h07;
  localparam logic [7:0]        INIT_RST    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT    = 2'd2;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] valve_states;
    logic                frame_good;
    logic                frame_bad;
    logic                timed_out;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       is_one;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] timeout_ticks;
    logic [7:0]        crc_poly;
    logic [7:0]        crc_init;
  } cfg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/crc_checked_valve_command_receiver.sv
// flow: an accepted transaction is written into the two-entry queue and its result is
//   registered into the output register when the back end pops it from the queue
// throughput: one transaction per cycle when not stalled, bytes and ticks alike; the byte
//   path is an unrolled crc-8 update and a two-entry queue decouples intake from output
// reset: synchronous active-low rst_n clears frame position, valves and idle counter,
//   loads register defaults (timeout 30000, poly 0x07, init 0x00); no clearing pass
`default_nettype none
module crc_checked_valve_command_receiver #(
  parameter int VALVE_COUNT = 10
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire vcr_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output vcr_pkg::out_item_t                     out_item,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [vcr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [vcr_pkg::CFG_W-1:0]               cfg_data
);

  vcr_pkg::cfg_t cfg_r;
  vcr_pkg::cmd_t front_cmd;
  vcr_pkg::cmd_t q_cmd;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= vcr_pkg::TIMEOUT_RST;
      cfg_r.crc_poly      <= vcr_pkg::POLY_RST;
      cfg_r.crc_init      <= vcr_pkg::INIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vcr_pkg::REG_TIMEOUT: cfg_r.timeout_ticks <= cfg_data[vcr_pkg::TICK_W-1:0];
        vcr_pkg::REG_POLY:    cfg_r.crc_poly      <= cfg_data[7:0];
        vcr_pkg::REG_INIT:    cfg_r.crc_init      <= cfg_data[7:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  vcr_front u_front (
    .item (in_item),
    .cmd  (front_cmd)
  );

  vcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_cmd   (q_cmd)
  );

  vcr_back #(
    .VALVE_COUNT (VALVE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### rtl/vcr_front.sv
`default_nettype none
module vcr_front (
  input  wire vcr_pkg::in_item_t item,
  output vcr_pkg::cmd_t          cmd
);

  always_comb begin
    cmd.kind   = item.func ? vcr_pkg::CMD_TICK : vcr_pkg::CMD_BYTE;
    cmd.data   = item.byte_value;
    cmd.is_one = (item.byte_value == vcr_pkg::ASCII_ONE);
  end

endmodule
`default_nettype wire

### rtl/vcr_queue.sv
`default_nettype none
module vcr_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire vcr_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire                 pop,
  output logic                not_empty,
  output vcr_pkg::cmd_t       pop_cmd
);

  vcr_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/vcr_back.sv
`default_nettype none
module vcr_back #(
  parameter int VALVE_COUNT = 10
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire vcr_pkg::cfg_t      cfg,
  input  wire                     q_valid,
  input  wire vcr_pkg::cmd_t      q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_stall,
  output vcr_pkg::out_item_t      out_item
);

  localparam int unsigned PW = vcr_pkg::POS_W;
  localparam int unsigned OB = vcr_pkg::OUT_BITS;
  localparam int unsigned TW = vcr_pkg::TICK_W;
  localparam logic [PW-1:0] LAST_POS = PW'(VALVE_COUNT);

  logic [PW-1:0]      pos_r, pos_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [OB-1:0]      pending_r, pending_nxt;
  logic [OB-1:0]      valves_r, valves_nxt;
  logic [TW-1:0]      idle_r, idle_nxt;
  logic               out_valid_r;
  vcr_pkg::out_item_t out_item_r, out_item_nxt;
  logic               good, bad, tout;
  logic [7:0]         crc_start;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign crc_start = (pos_r == '0) ? cfg.crc_init : crc_r;

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    pending_nxt = pending_r;
    valves_nxt  = valves_r;
    idle_nxt    = idle_r;
    good        = 1'b0;
    bad         = 1'b0;
    case (q_cmd.kind)
      vcr_pkg::CMD_BYTE: begin
        if (pos_r >= LAST_POS) begin
          if (q_cmd.data == crc_r) begin
            good       = 1'b1;
            valves_nxt = pending_r;
            idle_nxt   = '0;
          end else begin
            bad = 1'b1;
          end
          pos_nxt     = '0;
          pending_nxt = '0;
          crc_nxt     = cfg.crc_init;
        end else begin
          crc_nxt = vcr_pkg::crc8_byte(crc_start, q_cmd.data, cfg.crc_poly);
          for (int i = 0; i < OB; i++) begin
            if (q_cmd.is_one && pos_r == PW'(i)) begin
              pending_nxt[i] = 1'b1;
            end
          end
          pos_nxt = pos_r + PW'(1);
        end
      end
      vcr_pkg::CMD_TICK: begin
        if (idle_r < cfg.timeout_ticks) begin
          idle_nxt = idle_r + TW'(1);
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
    tout = (idle_nxt >= cfg.timeout_ticks);
    if (tout) begin
      valves_nxt = '0;
    end
    out_item_nxt.valve_states = valves_nxt;
    out_item_nxt.frame_good   = good;
    out_item_nxt.frame_bad    = bad;
    out_item_nxt.timed_out    = tout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= vcr_pkg::INIT_RST;
      pending_r   <= '0;
      valves_r    <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r     <= pos_nxt;
        crc_r     <= crc_nxt;
        pending_r <= pending_nxt;
        valves_r  <= valves_nxt;
        idle_r    <= idle_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
`default_nettype wire
